/* hw/rtl/osw_pkg.sv */
// ----------------------------------------------------------------------------
// osw_pkg
// Shared constants and types of the odd-symmetric waveshaper.
// ----------------------------------------------------------------------------
package osw_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = 9;
  localparam int unsigned IndexW     = 8;
  localparam int unsigned ValueW     = 16;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned ShapedW    = 17;
  localparam int unsigned PosW       = SampleW + CountW;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncShape = 1'b1;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [AddrW-1:0]  wr_addr;
    logic [ValueW-1:0] wr_data;
    logic [AddrW-1:0]  rd_addr_a;
    logic [AddrW-1:0]  rd_addr_b;
  } ram_req_t;

endpackage

/* hw/rtl/osw_curve_ram.sv */
// ----------------------------------------------------------------------------
// osw_curve_ram
// Curve point memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module osw_curve_ram (
  input  logic                       clk_i,
  input  osw_pkg::ram_req_t          req_i,
  output logic [osw_pkg::ValueW-1:0] rd_data_a_o,
  output logic [osw_pkg::ValueW-1:0] rd_data_b_o
);

  logic [osw_pkg::ValueW-1:0] mem_q [osw_pkg::TableDepth];
  logic [osw_pkg::ValueW-1:0] rd_a_q;
  logic [osw_pkg::ValueW-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem_q[req_i.wr_addr] <= req_i.wr_data;
      end
      rd_a_q <= mem_q[req_i.rd_addr_a];
      rd_b_q <= mem_q[req_i.rd_addr_b];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

/* hw/rtl/odd_symmetric_waveshaper_unit.sv */
// ----------------------------------------------------------------------------
// odd_symmetric_waveshaper_unit
// Table-driven odd-symmetric waveshaper with linear interpolation.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    func, entry_index, entry_value,
//                                                  sample, last_sample
//   out      output     out_valid_o / out_stall_i  shaped, last_out
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_data_i (entry_count)
//
// One item is accepted per cycle while not stalled; a sample item's result
// moves through the stage registers to the output register; a load item gives none.
// Stages: position multiply, table addressing, memory access, interpolation
// multiplies, rounding into the output register.
// Reset clears the valid bits and entry_count; the curve table is not cleared.
// While the output register holds an item that is stalled, the whole pipeline
// holds and in_stall_o is high.
// ----------------------------------------------------------------------------
module odd_symmetric_waveshaper_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [osw_pkg::CountW-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               func_i,
  input  logic [osw_pkg::IndexW-1:0]         entry_index_i,
  input  logic [osw_pkg::ValueW-1:0]         entry_value_i,
  input  logic signed [osw_pkg::SampleW-1:0] sample_i,
  input  logic                               last_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [osw_pkg::ShapedW-1:0] shaped_o,
  output logic                               last_out_o
);

  localparam int unsigned CW = osw_pkg::CountW;
  localparam int unsigned AW = osw_pkg::AddrW;
  localparam int unsigned VW = osw_pkg::ValueW;
  localparam int unsigned PW = osw_pkg::PosW;

  logic          adv;
  logic [CW-1:0] entry_count_q;
  logic [CW-1:0] n_d;
  logic [15:0]   u_d;
  logic [CW-1:0] m_d;
  logic [PW-1:0] pos_d;

  logic          s1_valid_q, s1_func_q, s1_last_q;
  logic [osw_pkg::IndexW-1:0] s1_idx_q;
  logic [VW-1:0] s1_val_q;
  logic [PW-1:0] s1_pos_q;
  logic [CW-1:0] s1_n_q;

  logic [CW-1:0] i_d;
  logic          ge_a, ge_b;
  logic [AW-1:0] addr_a_d, addr_b_d;
  logic          s2_valid_q, s2_func_q, s2_last_q, s2_zero_q;
  logic          s2_neg_a_q, s2_neg_b_q;
  logic [osw_pkg::IndexW-1:0] s2_idx_q;
  logic [VW-1:0] s2_val_q;
  logic [15:0]   s2_frac_q;
  logic [AW-1:0] s2_addr_a_q, s2_addr_b_q;

  osw_pkg::ram_req_t ram_req;
  logic [VW-1:0] rd_a, rd_b;
  logic          s3_valid_q, s3_func_q, s3_last_q, s3_zero_q;
  logic          s3_neg_a_q, s3_neg_b_q;
  logic [15:0]   s3_frac_q;

  logic signed [16:0] a_d, b_d;
  logic signed [17:0] wa_d, wb_d;
  logic signed [34:0] pa_d, pb_d;
  logic          s4_valid_q, s4_func_q, s4_last_q, s4_zero_q;
  logic signed [34:0] s4_pa_q, s4_pb_q;

  logic signed [34:0] sum_d;
  logic signed [34:0] rnd_d;
  logic signed [osw_pkg::ShapedW-1:0] shaped_d;
  logic          out_valid_q, out_valid_d, last_out_q;
  logic signed [osw_pkg::ShapedW-1:0] shaped_q;

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i) begin
      entry_count_q <= cfg_data_i;
    end
  end

  // Stage 1: clamp the count and form the position u * (2N - 1).
  always_comb begin
    n_d   = (entry_count_q > CW'(osw_pkg::TableDepth)) ?
            CW'(osw_pkg::TableDepth) : entry_count_q;
    u_d   = sample_i ^ 16'h8000;
    m_d   = {n_d[CW-2:0], 1'b0} - CW'(1);
    pos_d = PW'(u_d) * PW'(m_d);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_func_q <= func_i;
      s1_idx_q  <= entry_index_i;
      s1_val_q  <= entry_value_i;
      s1_last_q <= last_sample_i;
      s1_pos_q  <= pos_d;
      s1_n_q    <= n_d;
    end
  end

  // Stage 2: map full curve points i and i + 1 onto table addresses.
  always_comb begin
    i_d      = s1_pos_q[PW-1:16];
    ge_a     = i_d >= s1_n_q;
    ge_b     = i_d >= (s1_n_q - CW'(1));
    addr_a_d = ge_a ? AW'(i_d - s1_n_q) : AW'(s1_n_q - CW'(1) - i_d);
    addr_b_d = ge_b ? AW'(i_d + CW'(1) - s1_n_q) : AW'(s1_n_q - CW'(2) - i_d);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_func_q   <= s1_func_q;
      s2_idx_q    <= s1_idx_q;
      s2_val_q    <= s1_val_q;
      s2_last_q   <= s1_last_q;
      s2_zero_q   <= (s1_n_q == '0);
      s2_frac_q   <= s1_pos_q[15:0];
      s2_neg_a_q  <= !ge_a;
      s2_neg_b_q  <= !ge_b;
      s2_addr_a_q <= addr_a_d;
      s2_addr_b_q <= addr_b_d;
    end
  end

  // Stage 3: loads write and samples read in item order.
  always_comb begin
    ram_req.en        = adv;
    ram_req.we        = s2_valid_q && (s2_func_q == osw_pkg::FuncLoad) &&
                        (32'(s2_idx_q) < osw_pkg::TableDepth);
    ram_req.wr_addr   = AW'(s2_idx_q);
    ram_req.wr_data   = s2_val_q;
    ram_req.rd_addr_a = s2_addr_a_q;
    ram_req.rd_addr_b = s2_addr_b_q;
  end

  osw_curve_ram u_curve_ram (
    .clk_i       (clk_i),
    .req_i       (ram_req),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_func_q  <= s2_func_q;
      s3_last_q  <= s2_last_q;
      s3_zero_q  <= s2_zero_q;
      s3_frac_q  <= s2_frac_q;
      s3_neg_a_q <= s2_neg_a_q;
      s3_neg_b_q <= s2_neg_b_q;
    end
  end

  // Stage 4: weight both neighbors.
  always_comb begin
    a_d  = s3_neg_a_q ? -$signed({1'b0, rd_a}) : $signed({1'b0, rd_a});
    b_d  = s3_neg_b_q ? -$signed({1'b0, rd_b}) : $signed({1'b0, rd_b});
    wa_d = $signed(18'h10000 - {2'b00, s3_frac_q});
    wb_d = $signed({2'b00, s3_frac_q});
    pa_d = 35'(a_d) * 35'(wa_d);
    pb_d = 35'(b_d) * 35'(wb_d);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_func_q <= s3_func_q;
      s4_last_q <= s3_last_q;
      s4_zero_q <= s3_zero_q;
      s4_pa_q   <= pa_d;
      s4_pb_q   <= pb_d;
    end
  end

  // Stage 5: round to nearest with ties toward plus infinity.
  always_comb begin
    sum_d       = s4_pa_q + s4_pb_q;
    rnd_d       = sum_d + 35'sd32768;
    shaped_d    = s4_zero_q ? '0 : rnd_d[32:16];
    out_valid_d = s4_valid_q && (s4_func_q == osw_pkg::FuncShape);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      shaped_q   <= shaped_d;
      last_out_q <= s4_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign shaped_o    = shaped_q;
  assign last_out_o  = last_out_q;

endmodule

/* hw/rtl/osw_checker.sv */
// ----------------------------------------------------------------------------
// osw_checker
// Port-level assertions for the odd-symmetric waveshaper, bound to the top.
// ----------------------------------------------------------------------------
module osw_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               cfg_ready_o,
  input logic signed [osw_pkg::ShapedW-1:0] shaped_o,
  input logic                               last_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(shaped_o) && $stable(last_out_o))
    else $error("stalled output item changed");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output item");

  a_shaped_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shaped_o != 17'h10000)
    else $error("shaped result out of range");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind odd_symmetric_waveshaper_unit osw_checker u_osw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cfg_ready_o (cfg_ready_o),
  .shaped_o    (shaped_o),
  .last_out_o  (last_out_o)
);

/* bench/odd_symmetric_waveshaper_unit_test.sv */
// ----------------------------------------------------------------------------
// odd_symmetric_waveshaper_unit_test
// Self-checking bench for the odd-symmetric table waveshaper.
//
// A short directed table covers constant mode, the clamped ends of the
// sample range and one- and two-point curves. Random phases follow, each
// with its own entry_count. Every curve point that a sample can read is
// loaded before any sample is sent. Each shaped result is checked against
// a directed-table value or a bit-exact interpolation model in this bench.
// Both channels idle at random; one long output stall fills the pipeline.
// ----------------------------------------------------------------------------
module odd_symmetric_waveshaper_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 40;
  localparam int unsigned PhaseItems   = 28;
  localparam int unsigned NumPhases    = 9;
  localparam int unsigned NumRows      = 20;

  localparam int unsigned PhaseCounts [NumPhases] = '{3, 64, 2, 128, 511, 256, 1, 0, 200};

  typedef enum logic {RowItem, RowConfig} row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic                        func;
    logic [osw_pkg::IndexW-1:0]  index;
    logic [osw_pkg::ValueW-1:0]  value;
    logic [osw_pkg::SampleW-1:0] smp;
    logic                        last;
    logic                        known;
    logic [osw_pkg::ShapedW-1:0] want;
    logic [osw_pkg::CountW-1:0]  count;
  } stim_row_t;

  typedef struct packed {
    logic [osw_pkg::ShapedW-1:0] shaped;
    logic                        last;
  } shaped_result_t;

  // Columns: kind, func, index, value, sample, last, known, expected, count.
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{RowItem,   osw_pkg::FuncShape, 8'd0,   16'h0000, 16'h8000, 1'b1, 1'b1, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncShape, 8'd0,   16'h0000, 16'h7FFF, 1'b0, 1'b1, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncShape, 8'd0,   16'h0000, 16'h0000, 1'b1, 1'b1, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncLoad,  8'd0,   16'hFFFF, 16'h0000, 1'b0, 1'b0, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncLoad,  8'd1,   16'h0000, 16'hFFFF, 1'b1, 1'b0, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncLoad,  8'd255, 16'hA5A5, 16'h5A5A, 1'b0, 1'b0, 17'h00000, 9'd0},
    '{RowConfig, osw_pkg::FuncLoad,  8'd0,   16'h0000, 16'h0000, 1'b0, 1'b0, 17'h00000, 9'd1},
    '{RowItem,   osw_pkg::FuncShape, 8'd255, 16'hFFFF, 16'h8000, 1'b1, 1'b1, 17'h10001, 9'd0},
    '{RowItem,   osw_pkg::FuncShape, 8'd0,   16'h0000, 16'h7FFF, 1'b0, 1'b0, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncShape, 8'd0,   16'h0000, 16'h0000, 1'b1, 1'b0, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncShape, 8'd0,   16'h0000, 16'hFFFF, 1'b0, 1'b0, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncLoad,  8'd0,   16'h0000, 16'h1234, 1'b0, 1'b0, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncLoad,  8'd1,   16'hFFFF, 16'h0000, 1'b1, 1'b0, 17'h00000, 9'd0},
    '{RowConfig, osw_pkg::FuncLoad,  8'd0,   16'h0000, 16'h0000, 1'b0, 1'b0, 17'h00000, 9'd2},
    '{RowItem,   osw_pkg::FuncShape, 8'd0,   16'h0000, 16'h8000, 1'b0, 1'b1, 17'h10001, 9'd0},
    '{RowItem,   osw_pkg::FuncShape, 8'd0,   16'h0000, 16'h7FFF, 1'b1, 1'b0, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncShape, 8'd0,   16'h0000, 16'h4000, 1'b0, 1'b0, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncShape, 8'd0,   16'h0000, 16'hBFFF, 1'b1, 1'b0, 17'h00000, 9'd0},
    '{RowConfig, osw_pkg::FuncLoad,  8'd0,   16'h0000, 16'h0000, 1'b0, 1'b0, 17'h00000, 9'd0},
    '{RowItem,   osw_pkg::FuncShape, 8'd0,   16'h0000, 16'h3039, 1'b1, 1'b1, 17'h00000, 9'd0}
  };

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic [osw_pkg::CountW-1:0]         cfg_data_i    = '0;
  logic                               in_valid_i    = 1'b0;
  logic                               in_stall_o;
  logic                               func_i        = osw_pkg::FuncLoad;
  logic [osw_pkg::IndexW-1:0]         entry_index_i = '0;
  logic [osw_pkg::ValueW-1:0]         entry_value_i = '0;
  logic signed [osw_pkg::SampleW-1:0] sample_i      = '0;
  logic                               last_sample_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i   = 1'b1;
  logic signed [osw_pkg::ShapedW-1:0] shaped_o;
  logic                               last_out_o;

  logic [osw_pkg::ValueW-1:0] curve_copy [osw_pkg::TableDepth];
  bit                         written_map [osw_pkg::TableDepth];
  logic [osw_pkg::CountW-1:0] active_count = '0;
  shaped_result_t             shaped_q [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  int unsigned mismatch_count = 0;
  int unsigned checked_count  = 0;
  int unsigned load_total     = 0;
  int unsigned sample_total   = 0;
  int unsigned cfg_total      = 0;

  odd_symmetric_waveshaper_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .shaped_o      (shaped_o),
    .last_out_o    (last_out_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint curve_point(input int unsigned j, input int unsigned n);
    if (j >= n) begin
      return longint'(curve_copy[j - n]);
    end
    return -longint'(curve_copy[n - 1 - j]);
  endfunction

  function automatic logic [osw_pkg::ShapedW-1:0] predict_shaped(
    input logic [osw_pkg::SampleW-1:0] smp);
    int unsigned n;
    int unsigned m;
    int unsigned pos;
    int unsigned i;
    int unsigned f;
    longint      acc;
    n = (active_count > osw_pkg::TableDepth) ? osw_pkg::TableDepth : active_count;
    if (n == 0) begin
      return '0;
    end
    m   = 2 * n - 1;
    pos = {16'd0, smp ^ 16'h8000} * m;
    i   = pos >> 16;
    f   = pos & 32'h0000FFFF;
    acc = curve_point(i, n) * longint'(65536 - f) + curve_point(i + 1, n) * longint'(f);
    acc = (acc + 64'sd32768) >>> 16;
    return acc[osw_pkg::ShapedW-1:0];
  endfunction

  task automatic send_item(input logic func, input logic [osw_pkg::IndexW-1:0] index,
                           input logic [osw_pkg::ValueW-1:0] value,
                           input logic [osw_pkg::SampleW-1:0] smp,
                           input logic last, input logic known,
                           input logic [osw_pkg::ShapedW-1:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= func;
    entry_index_i <= index;
    entry_value_i <= value;
    sample_i      <= smp;
    last_sample_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (func == osw_pkg::FuncLoad) begin
      curve_copy[index]  = value;
      written_map[index] = 1'b1;
      load_total++;
    end else begin
      shaped_q.push_back('{known ? want : predict_shaped(smp), last});
      sample_total++;
    end
    @(negedge clk_i);
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (shaped_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_entry_count(input logic [osw_pkg::CountW-1:0] count);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    active_count = count;
    cfg_total++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    shaped_result_t oldest;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (shaped_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual shaped %0d last %0b",
                 $time, shaped_o, last_out_o);
        mismatch_count++;
      end else begin
        oldest = shaped_q.pop_front();
        checked_count++;
        if (shaped_o !== oldest.shaped) begin
          $display("%0t: shaped mismatch: expected %0d, actual %0d",
                   $time, $signed(oldest.shaped), shaped_o);
          mismatch_count++;
        end
        if (last_out_o !== oldest.last) begin
          $display("%0t: last_out mismatch: expected %0b, actual %0b",
                   $time, oldest.last, last_out_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned                 k;
    int unsigned                 p;
    int unsigned                 fill;
    stim_row_t                   row;
    logic                        rnd_func;
    logic [osw_pkg::ValueW-1:0]  rnd_value;
    logic [osw_pkg::SampleW-1:0] rnd_smp;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 6;
    recv_idle_pct = 56;
    for (k = 0; k < NumRows; k++) begin
      row = DirectedRows[k];
      if (row.kind == RowConfig) begin
        drain_and_settle();
        write_entry_count(row.count);
      end else begin
        send_item(row.func, row.index, row.value, row.smp, row.last, row.known, row.want);
      end
    end

    for (p = 0; p < NumPhases; p++) begin
      send_idle_pct = (p < 3) ? 6 : (p < 6) ? 56 : 0;
      recv_idle_pct = (p < 3) ? 56 : (p < 6) ? 6 : 0;
      drain_and_settle();
      write_entry_count(PhaseCounts[p][osw_pkg::CountW-1:0]);
      // Every point that a sample may read must hold a known value.
      fill = (PhaseCounts[p] > osw_pkg::TableDepth) ? osw_pkg::TableDepth : PhaseCounts[p];
      for (k = 0; k < fill; k++) begin
        if (!written_map[k]) begin
          send_item(osw_pkg::FuncLoad, k[osw_pkg::IndexW-1:0],
                    osw_pkg::ValueW'($urandom), osw_pkg::SampleW'($urandom),
                    1'($urandom), 1'b0, '0);
        end
      end
      for (k = 0; k < PhaseItems; k++) begin
        if (p == 2 && k == 14) begin
          drain_and_settle();
        end
        if (p == 6 && k == 4) begin
          hold_request = HoldCycles;
        end
        rnd_func = ($urandom_range(99) < 70) ? osw_pkg::FuncShape : osw_pkg::FuncLoad;
        if ($urandom_range(7) == 0) begin
          rnd_value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end else begin
          rnd_value = osw_pkg::ValueW'($urandom);
        end
        case ($urandom_range(11))
          0:       rnd_smp = 16'h8000;
          1:       rnd_smp = 16'h7FFF;
          2:       rnd_smp = 16'h0000;
          3:       rnd_smp = 16'hFFFF;
          default: rnd_smp = osw_pkg::SampleW'($urandom);
        endcase
        send_item(rnd_func, osw_pkg::IndexW'($urandom), rnd_value, rnd_smp,
                  1'($urandom), 1'b0, '0);
      end
    end

    drain_and_settle();
    if (shaped_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, shaped_q.size());
      mismatch_count += shaped_q.size();
    end

    $display("Run covered %0d curve loads, %0d shaped samples and %0d entry_count writes.",
             load_total, sample_total, cfg_total);
    $display("Results compared: %0d, mismatches found: %0d.", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/osw_pkg.sv
hw/rtl/osw_curve_ram.sv
hw/rtl/odd_symmetric_waveshaper_unit.sv
hw/rtl/osw_checker.sv
bench/odd_symmetric_waveshaper_unit_test.sv
